/* hdl/bbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur package
// Shared widths, types, register indexes and helper functions of the
// 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
package bbl_pkg;

  // Frame geometry.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

  // Configuration register widths and reset values.
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int WCMP_W     = (FW_W > COL_W) ? FW_W : COL_W;
  localparam int HCMP_W     = (FH_W > ROW_W) ? FH_W : ROW_W;
  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd768;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Pixel data.
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Averaging arithmetic: sum of up to nine channels, numerator 2*sum+count.
  localparam int SUM_W  = 12;
  localparam int NUM_W  = SUM_W + 1;
  localparam int OP_W   = NUM_W - 1;
  localparam int CNT_W  = 4;
  localparam int PROD_W = 24;
  localparam logic [OP_W-1:0] RECIP3    = 12'd2731;  // ceil(2^13 / 3)
  localparam int              RECIP3_SH = 13;
  localparam logic [OP_W-1:0] RECIP9    = 12'd1821;  // ceil(2^14 / 9)
  localparam int              RECIP9_SH = 14;

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pixel_t;

  // One neighborhood to be averaged, with its in-frame masks.
  typedef struct packed {
    pixel_t [8:0] win;
    logic [2:0]   col_mask;
    logic [2:0]   row_mask;
    logic         frame_end;
  } emit_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } result_t;

  // Write request into the two line stores.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    pixel_t            older;
    pixel_t            newer;
  } line_wr_t;

  function automatic logic [COL_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [WCMP_W-1:0] v;
    v = WCMP_W'(fw);
    if (fw == '0) return COL_W'(1);
    if (v > WCMP_W'(MAX_WIDTH)) return COL_W'(MAX_WIDTH);
    return COL_W'(v);
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [FH_W-1:0] fh);
    logic [HCMP_W-1:0] v;
    v = HCMP_W'(fh);
    if (fh == '0) return ROW_W'(1);
    if (v > HCMP_W'(MAX_HEIGHT)) return ROW_W'(MAX_HEIGHT);
    return ROW_W'(v);
  endfunction

endpackage

/* hdl/bbl_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur channel interfaces
// Valid/ready channels for pixels in, blurred pixels out and register writes.
// ----------------------------------------------------------------------------
interface bbl_pix_if import bbl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;
  logic            drain;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, drain, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, drain, output ready);
endinterface

interface bbl_blur_if import bbl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] blur_red;
  logic [CH_W-1:0] blur_green;
  logic [CH_W-1:0] blur_blue;
  logic            frame_end;

  modport source (output valid, blur_red, blur_green, blur_blue, frame_end, input ready);
  modport sink   (input valid, blur_red, blur_green, blur_blue, frame_end, output ready);
endinterface

interface bbl_cfg_if import bbl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bbl_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur line store
// Two row memories, one write and one registered read per cycle, shared
// address per port.
// ----------------------------------------------------------------------------
module bbl_line_store import bbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  line_wr_t          wr_i,
  output pixel_t            rd_older_o,
  output pixel_t            rd_newer_o
);

  pixel_t older_mem [MAX_WIDTH];
  pixel_t newer_mem [MAX_WIDTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      older_mem[wr_i.addr] <= wr_i.older;
      newer_mem[wr_i.addr] <= wr_i.newer;
    end
    if (rd_en_i) begin
      rd_older_o <= older_mem[rd_addr_i];
      rd_newer_o <= newer_mem[rd_addr_i];
    end
  end

endmodule

/* hdl/bbl_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur averaging pipeline
// Masked neighborhood sum in one stage, rounded division by the neighbor
// count in the next.
// ----------------------------------------------------------------------------
module bbl_average import bbl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       emit_valid_i,
  input  emit_t      emit_i,
  output logic       res_valid_o,
  output result_t    res_o,
  output logic [1:0] busy_o
);

  logic [2:0][SUM_W-1:0] sum_d, sum_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [1:0]            ncols, nrows;
  logic                  fe_q;
  logic                  s2_valid_q;
  logic                  res_valid_q;
  result_t               res_d, res_q;
  logic [2:0][NUM_W-1:0]  num;
  logic [2:0][OP_W-1:0]   op;
  logic [2:0][PROD_W-1:0] prod;
  logic [2:0][CH_W-1:0]   quo;
  logic [OP_W-1:0]        recip;

  // Sum stage.
  always_comb begin
    ncols = 2'(emit_i.col_mask[0]) + 2'(emit_i.col_mask[1]) + 2'(emit_i.col_mask[2]);
    nrows = 2'(emit_i.row_mask[0]) + 2'(emit_i.row_mask[1]) + 2'(emit_i.row_mask[2]);
    cnt_d = CNT_W'(ncols) * CNT_W'(nrows);
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (emit_i.col_mask[k] && emit_i.row_mask[j]) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(emit_i.win[k*3+j][(2-ch)*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // Divide stage: floor((2*sum + n) / (2*n)) with n in {1,2,3,4,6,9}.
  // Powers of two are shifts; factors of three and nine use reciprocals.
  always_comb begin
    recip = (cnt_q == CNT_W'(9)) ? RECIP9 : RECIP3;
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {sum_q[ch], 1'b0} + NUM_W'(cnt_q);
      op[ch]   = (cnt_q == CNT_W'(6)) ? OP_W'(num[ch] >> 2) : OP_W'(num[ch] >> 1);
      prod[ch] = PROD_W'(op[ch]) * PROD_W'(recip);
      case (cnt_q)
        CNT_W'(2):            quo[ch] = CH_W'(num[ch] >> 2);
        CNT_W'(4):            quo[ch] = CH_W'(num[ch] >> 3);
        CNT_W'(3), CNT_W'(6): quo[ch] = CH_W'(prod[ch] >> RECIP3_SH);
        CNT_W'(9):            quo[ch] = CH_W'(prod[ch] >> RECIP9_SH);
        default:              quo[ch] = CH_W'(num[ch] >> 1);
      endcase
    end
    res_d.red       = quo[0];
    res_d.green     = quo[1];
    res_d.blue      = quo[2];
    res_d.frame_end = fe_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= emit_valid_i;
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid_i) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      fe_q  <= emit_i.frame_end;
    end
    if (s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign busy_o      = 2'(s2_valid_q) + 2'(res_valid_q);

endmodule

/* hdl/bbl_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur output queue
// Small register queue that holds finished results until the receiver
// takes them.
// ----------------------------------------------------------------------------
module bbl_out_fifo import bbl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               push_data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output result_t               data_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  result_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + FIFO_CNT_W'(1);
    if (!push_i && pop_i) count_d = count_q - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= FIFO_PTR_W'((32'(wr_ptr_q) + 1) % FIFO_DEPTH);
      if (pop_i)  rd_ptr_q <= FIFO_PTR_W'((32'(rd_ptr_q) + 1) % FIFO_DEPTH);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries[wr_ptr_q] <= push_data_i;
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entries[rd_ptr_q];
  assign count_o = count_q;

endmodule

/* hdl/box_blur_3x3_edge_clipped_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 edge-clipped box blur
// Streams RGB pixels in raster order and returns each pixel as the rounded
// mean of its in-frame 3x3 neighborhood.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one pixel per transfer, or a drain item (drain = 1) that
//   pushes the last row out after a frame; a frame needs frame_width + 1
//   drain transfers after its last pixel. blur_o returns one result per
//   transfer in raster order; frame_end marks the last pixel of the frame.
//   cfg_i writes frame_width (index 0) or frame_height (index 1); a write
//   takes effect at once, restarts the frame at pixel (0,0) and clears the
//   window. Write only while the block is idle.
// Latency and rate:
//   One transfer per clock is accepted while pix_i.ready is high. A result
//   leaves about one row after its pixel enters: pixel (r-1, c-1) is produced
//   by input (r, c), and reaches blur_o through the line store read, window
//   and sum, divide and queue write. Rate is set by the single line store
//   port pair, which reads and writes one column per cycle.
// Reset and stalls:
//   Reset clears position, window and queues; the line stores need no
//   clearing. When the receiver stalls, results collect in an eight-entry
//   queue and pix_i.ready drops only once the queue plus the items still in
//   the pipeline would fill it.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_unit import bbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbl_cfg_if.sink     cfg_i,
  bbl_pix_if.sink     pix_i,
  bbl_blur_if.source  blur_o
);

  localparam int CRD_W = FIFO_CNT_W + 1;

  // Pipeline register between the position logic and the window.
  typedef struct packed {
    logic              col_zero;
    logic              col_in;
    logic              we;
    logic [ADDR_W-1:0] addr;
    pixel_t            px;
    logic              fwd;
    pixel_t            fwd_older;
    pixel_t            fwd_newer;
    logic              emit_a;
    logic              emit_b;
    logic [2:0]        col_mask;
    logic [2:0]        row_mask;
    logic              frame_end;
  } s1_t;

  // Configuration and position state.
  logic [COL_W-1:0] eff_w_q;
  logic [ROW_W-1:0] eff_h_q;
  logic [COL_W-1:0] col_q, col_d, cur_col;
  logic [ROW_W-1:0] row_q, row_d, cur_row;
  logic [COL_W:0]   col_inc;

  logic cfg_fire, cfg_hit;
  logic in_fire, at_drain_row, skip, restart, drain_step;
  logic col_zero, col_in, emit_a, emit_b;
  logic [ADDR_W-1:0] rd_addr;
  pixel_t            px_in;

  s1_t  s1_d, s1_q;
  logic s1_valid_q;

  pixel_t   rd_older, rd_newer, s1_older, s1_newer;
  line_wr_t line_wr;

  pixel_t [8:0] window_q, win_a, win_f;

  logic       emit_valid;
  emit_t      emit;
  logic       res_valid;
  result_t    res;
  logic [1:0] avg_busy;

  logic                  fifo_pop;
  result_t               fifo_data;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_hit     = cfg_fire && ((cfg_i.index == REG_FRAME_WIDTH) ||
                                    (cfg_i.index == REG_FRAME_HEIGHT));

  // --------------------------------------------------------------------------
  // Input side: position tracking and line store read
  // --------------------------------------------------------------------------
  // Only admit an item when its result is sure to find room in the queue.
  assign pix_i.ready = (CRD_W'(fifo_count) + CRD_W'(s1_valid_q) + CRD_W'(avg_busy))
                       < CRD_W'(FIFO_DEPTH);
  assign in_fire = pix_i.valid && pix_i.ready;

  always_comb begin
    // The row after the last one is the virtual drain row. A drain item
    // outside it is ignored, and a pixel inside it starts a new frame.
    at_drain_row = (row_q == eff_h_q);
    skip         = !at_drain_row && pix_i.drain;
    restart      = at_drain_row && !pix_i.drain;
    drain_step   = at_drain_row && pix_i.drain;
    cur_col      = restart ? '0 : col_q;
    cur_row      = restart ? '0 : row_q;
    px_in        = drain_step ? '0 : {pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue};

    col_zero = (cur_col == '0);
    col_in   = (cur_col < eff_w_q);
    rd_addr  = cur_col[ADDR_W-1:0];

    // At the start of a row the window first finishes the previous row's
    // last pixel; otherwise it produces the pixel one up and one left.
    emit_a = col_zero && (cur_row >= ROW_W'(2));
    emit_b = !col_zero && (cur_row != '0);

    s1_d.col_zero  = col_zero;
    s1_d.col_in    = col_in;
    s1_d.we        = !drain_step;
    s1_d.addr      = rd_addr;
    s1_d.px        = px_in;
    // The item in the window stage writes this column at the same edge.
    s1_d.fwd       = s1_valid_q && s1_q.we && (s1_q.addr == rd_addr);
    s1_d.fwd_older = s1_newer;
    s1_d.fwd_newer = s1_q.px;
    s1_d.emit_a    = emit_a;
    s1_d.emit_b    = emit_b;
    if (emit_a) begin
      s1_d.col_mask = {1'b0, 1'b1, eff_w_q >= COL_W'(2)};
      s1_d.row_mask = {1'b1, 1'b1, cur_row >= ROW_W'(3)};
    end else begin
      s1_d.col_mask = {col_in, 1'b1, cur_col >= COL_W'(2)};
      s1_d.row_mask = {!drain_step, 1'b1, cur_row >= ROW_W'(2)};
    end
    s1_d.frame_end = emit_b && drain_step && (cur_col == eff_w_q);

    // Advance the position; the drain row runs one column past the width.
    col_inc = (COL_W+1)'(cur_col) + (COL_W+1)'(1);
    col_d   = COL_W'(col_inc);
    row_d   = cur_row;
    if (!drain_step) begin
      if (col_inc >= {1'b0, eff_w_q}) begin
        col_d = '0;
        row_d = cur_row + ROW_W'(1);
      end
    end else if (col_inc > {1'b0, eff_w_q}) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= eff_width(FW_RESET);
      eff_h_q    <= eff_height(FH_RESET);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire && !skip;
      if (cfg_hit) begin
        col_q <= '0;
        row_q <= '0;
        case (cfg_i.index)
          REG_FRAME_WIDTH:  eff_w_q <= eff_width(cfg_i.data[FW_W-1:0]);
          REG_FRAME_HEIGHT: eff_h_q <= eff_height(cfg_i.data[FH_W-1:0]);
          default: ;
        endcase
      end else if (in_fire && !skip) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !skip) s1_q <= s1_d;
  end

  bbl_line_store u_line_store (
    .clk_i      (clk_i),
    .rd_en_i    (in_fire && !skip && col_in),
    .rd_addr_i  (rd_addr),
    .wr_i       (line_wr),
    .rd_older_o (rd_older),
    .rd_newer_o (rd_newer)
  );

  // --------------------------------------------------------------------------
  // Window stage: read data arrives, rows move down one store, window shifts
  // --------------------------------------------------------------------------
  always_comb begin
    s1_older = s1_q.fwd ? s1_q.fwd_older : rd_older;
    s1_newer = s1_q.fwd ? s1_q.fwd_newer : rd_newer;

    line_wr.en    = s1_valid_q && s1_q.we;
    line_wr.addr  = s1_q.addr;
    line_wr.older = s1_newer;
    line_wr.newer = s1_q.px;

    // Entering a new row pushes an empty column first.
    win_a = window_q;
    if (s1_q.col_zero) begin
      win_a = {{3{PIX_W'(0)}}, window_q[8:3]};
    end
    if (s1_q.col_in) begin
      win_f = {s1_q.px, s1_newer, s1_older, win_a[8:3]};
    end else begin
      win_f = {{3{PIX_W'(0)}}, win_a[8:3]};
    end

    emit_valid     = s1_valid_q && (s1_q.emit_a || s1_q.emit_b);
    emit.win       = s1_q.emit_a ? win_a : win_f;
    emit.col_mask  = s1_q.col_mask;
    emit.row_mask  = s1_q.row_mask;
    emit.frame_end = s1_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (cfg_hit) begin
      window_q <= '0;
    end else if (s1_valid_q) begin
      window_q <= win_f;
    end
  end

  // --------------------------------------------------------------------------
  // Averaging and output queue
  // --------------------------------------------------------------------------
  bbl_average u_average (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_i       (emit),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .busy_o       (avg_busy)
  );

  assign fifo_pop = blur_o.valid && blur_o.ready;

  bbl_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (fifo_pop),
    .valid_o     (blur_o.valid),
    .data_o      (fifo_data),
    .count_o     (fifo_count)
  );

  assign blur_o.blur_red   = fifo_data.red;
  assign blur_o.blur_green = fifo_data.green;
  assign blur_o.blur_blue  = fifo_data.blue;
  assign blur_o.frame_end  = fifo_data.frame_end;

endmodule
